@@ hdl/sgr_pkg.sv @@
// sgr_pkg: shared types, constants and the direction state table for the
// swipe gesture recognizer. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package sgr_pkg;

  localparam int CoordBits     = 12;
  localparam int MinDistBits   = 13;
  localparam int StateBits     = 4;
  localparam int DirBits       = 3;
  localparam int CfgIdxBits    = 2;
  localparam int IgnoreCountDef = 2;

  localparam logic [StateBits-1:0] StateStart   = 4'd0;
  localparam logic [StateBits-1:0] StateNone    = 4'd1;
  localparam logic [StateBits-1:0] StateDirBase = 4'd2;
  localparam logic [StateBits-1:0] StateDirLast = 4'd9;

  localparam logic [MinDistBits-1:0] MinDistReset = 13'd10;

  typedef enum logic [1:0] {
    KindStart = 2'd0,
    KindPoint = 2'd1,
    KindUp    = 2'd2
  } kind_e;

  typedef enum logic [CfgIdxBits-1:0] {
    RegEnable  = 2'd0,
    RegMinDist = 2'd1
  } cfg_reg_e;

  typedef struct packed {
    logic [1:0]           kind;
    logic [CoordBits-1:0] pos_x;
    logic [CoordBits-1:0] pos_y;
  } sgr_in_t;

  typedef struct packed {
    logic [DirBits-1:0]   gesture;
    logic [CoordBits-1:0] start_x;
    logic [CoordBits-1:0] start_y;
  } sgr_out_t;

  typedef struct packed {
    logic               step;
    logic [DirBits-1:0] dir;
  } move_t;

  // ten-state table: start branches on the first direction, a repeat of the
  // held direction keeps it, anything else falls to the no-direction state
  function automatic logic [StateBits-1:0] step_state(input logic [StateBits-1:0] st,
                                                      input logic [DirBits-1:0] dir);
    logic [StateBits-1:0] dir_state;
    dir_state = StateDirBase + {1'b0, dir};
    if (st == StateStart) begin
      return dir_state;
    end else if (st >= StateDirBase && st <= StateDirLast && st == dir_state) begin
      return st;
    end else begin
      return StateNone;
    end
  endfunction

endpackage

`default_nettype wire

@@ hdl/swipe_gesture_recognizer.sv @@
// Swipe gesture recognizer: one touch request per cycle while the skid
// stage is empty; a contact-up result is registered in the output register,
// or parked in the skid stage while the output stalls. The classifier and
// the state step settle in the accept cycle, the cell chain shifts on it.
// Reset: recognizer disabled, min_distance 10, recognition cleared, no
// result pending. Depends on sgr_pkg, sgr_classify, sgr_cell, sgr_out_buf.
`timescale 1ns / 1ps
`default_nettype none

module swipe_gesture_recognizer
  import sgr_pkg::*;
#(
  parameter int IGNORE_COUNT = IgnoreCountDef
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  sgr_in_t                in_req_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output sgr_out_t               out_rsp_o,
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [CfgIdxBits-1:0]  cfg_index_i,
  input  logic [MinDistBits-1:0] cfg_data_i
);

  localparam int McBits = $clog2(2 * IGNORE_COUNT + 1);
  localparam logic [McBits-1:0] McFill = McBits'(IGNORE_COUNT);
  localparam logic [McBits-1:0] McRun  = McBits'(2 * IGNORE_COUNT);

  logic                   enable_q, enable_d;
  logic [MinDistBits-1:0] min_dist_q, min_dist_d;
  logic [StateBits-1:0]   cur_state_q, cur_state_d;
  logic                   have_last_q, have_last_d;
  logic [CoordBits-1:0]   last_x_q, last_x_d, last_y_q, last_y_d;
  logic [CoordBits-1:0]   origin_x_q, origin_x_d, origin_y_q, origin_y_d;
  logic [McBits-1:0]      mc_q, mc_d;

  logic [StateBits-1:0] chain [IGNORE_COUNT];
  logic [StateBits-1:0] new_state, prev_state;

  logic     accept, cfg_fire, clear, point, first, step, shift, rsp_valid, space;
  move_t    move;
  sgr_out_t rsp;

  assign cfg_ready_o = 1'b1;
  assign cfg_fire    = cfg_valid_i && cfg_ready_o;
  assign in_ready_o  = space;
  assign accept      = in_valid_i && in_ready_o;

  sgr_classify u_classify (
    .pos_x_i   (in_req_i.pos_x),
    .pos_y_i   (in_req_i.pos_y),
    .last_x_i  (last_x_q),
    .last_y_i  (last_y_q),
    .min_dist_i(min_dist_q),
    .move_o    (move)
  );

  // chain of delay cells: cell 0 holds the newest table state
  for (genvar k = 0; k < IGNORE_COUNT; k++) begin : g_cell
    sgr_cell u_cell (
      .clk_i  (clk_i),
      .shift_i(shift),
      .state_i((k == 0) ? new_state : chain[(k == 0) ? 0 : k - 1]),
      .state_o(chain[k])
    );
  end

  always_comb begin
    enable_d   = enable_q;
    min_dist_d = min_dist_q;
    clear      = 1'b0;
    if (cfg_fire) begin
      unique case (cfg_index_i)
        RegEnable: begin
          enable_d = cfg_data_i[0];
          clear    = enable_q && !cfg_data_i[0];
        end
        RegMinDist: min_dist_d = cfg_data_i;
        default: ;
      endcase
    end

    point = 1'b0;
    if (accept && enable_q) begin
      unique case (in_req_i.kind)
        KindStart: clear = 1'b1;
        KindPoint: point = 1'b1;
        default: ;
      endcase
    end

    first = point && !have_last_q;
    step  = point && have_last_q && move.step;
    shift = step && (mc_q >= McFill);

    // the first counted move steps from the start state
    prev_state = (mc_q == McFill) ? StateStart : chain[0];
    new_state  = step_state(prev_state, move.dir);

    rsp_valid = accept && enable_q && (in_req_i.kind == KindUp) &&
                (cur_state_q >= StateDirBase) && (cur_state_q <= StateDirLast);
    rsp.gesture = DirBits'(cur_state_q - StateDirBase);
    rsp.start_x = origin_x_q;
    rsp.start_y = origin_y_q;
  end

  always_comb begin
    cur_state_d = cur_state_q;
    have_last_d = have_last_q;
    last_x_d    = last_x_q;
    last_y_d    = last_y_q;
    origin_x_d  = origin_x_q;
    origin_y_d  = origin_y_q;
    mc_d        = mc_q;
    if (clear) begin
      cur_state_d = StateStart;
      have_last_d = 1'b0;
      last_x_d    = '0;
      last_y_d    = '0;
      origin_x_d  = '0;
      origin_y_d  = '0;
      mc_d        = '0;
    end else if (first) begin
      have_last_d = 1'b1;
      last_x_d    = in_req_i.pos_x;
      last_y_d    = in_req_i.pos_y;
      origin_x_d  = in_req_i.pos_x;
      origin_y_d  = in_req_i.pos_y;
    end else if (step) begin
      last_x_d = in_req_i.pos_x;
      last_y_d = in_req_i.pos_y;
      if (mc_q >= McRun) cur_state_d = chain[IGNORE_COUNT-1];
      else               mc_d = mc_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q    <= 1'b0;
      min_dist_q  <= MinDistReset;
      cur_state_q <= StateStart;
      have_last_q <= 1'b0;
      last_x_q    <= '0;
      last_y_q    <= '0;
      origin_x_q  <= '0;
      origin_y_q  <= '0;
      mc_q        <= '0;
    end else begin
      enable_q    <= enable_d;
      min_dist_q  <= min_dist_d;
      cur_state_q <= cur_state_d;
      have_last_q <= have_last_d;
      last_x_q    <= last_x_d;
      last_y_q    <= last_y_d;
      origin_x_q  <= origin_x_d;
      origin_y_q  <= origin_y_d;
      mc_q        <= mc_d;
    end
  end

  sgr_out_buf u_out_buf (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rsp_valid_i(rsp_valid),
    .rsp_i      (rsp),
    .space_o    (space),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_rsp_o  (out_rsp_o)
  );

endmodule

`default_nettype wire

@@ hdl/sgr_classify.sv @@
// sgr_classify: move detection and eight-way direction classification.
// Depends on sgr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sgr_classify
  import sgr_pkg::*;
(
  input  logic [CoordBits-1:0]   pos_x_i,
  input  logic [CoordBits-1:0]   pos_y_i,
  input  logic [CoordBits-1:0]   last_x_i,
  input  logic [CoordBits-1:0]   last_y_i,
  input  logic [MinDistBits-1:0] min_dist_i,
  output move_t                  move_o
);

  logic signed [CoordBits:0] dx, dy;
  logic [CoordBits-1:0]      adx, ady, diff, half;
  logic [CoordBits:0]        span;
  logic                      x_major, diag, dx_pos, dy_pos;

  always_comb begin
    dx = $signed({1'b0, pos_x_i}) - $signed({1'b0, last_x_i});
    dy = $signed({1'b0, pos_y_i}) - $signed({1'b0, last_y_i});
    adx = dx[CoordBits] ? CoordBits'(-dx) : CoordBits'(dx);
    ady = dy[CoordBits] ? CoordBits'(-dy) : CoordBits'(dy);
    span = {1'b0, adx} + {1'b0, ady};
    x_major = adx > ady;
    diff = x_major ? (adx - ady) : (ady - adx);
    half = x_major ? (adx >> 1) : (ady >> 1);
    diag = diff <= half;
    dx_pos = !dx[CoordBits] && (dx != '0);
    dy_pos = !dy[CoordBits] && (dy != '0);

    move_o.step = span >= min_dist_i;
    if (diag) begin
      if (dx_pos) move_o.dir = dy_pos ? 3'd7 : 3'd1;
      else        move_o.dir = dy_pos ? 3'd5 : 3'd3;
    end else if (x_major) begin
      move_o.dir = dx_pos ? 3'd0 : 3'd4;
    end else begin
      move_o.dir = dy_pos ? 3'd6 : 3'd2;
    end
  end

endmodule

`default_nettype wire

@@ hdl/sgr_cell.sv @@
// sgr_cell: one delay cell of the table-state chain; loads its neighbor's
// state on every counted move. Depends on sgr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sgr_cell
  import sgr_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 shift_i,
  input  logic [StateBits-1:0] state_i,
  output logic [StateBits-1:0] state_o
);

  logic [StateBits-1:0] state_q, state_d;

  always_comb begin
    state_d = shift_i ? state_i : state_q;
  end

  always_ff @(posedge clk_i) begin
    state_q <= state_d;
  end

  assign state_o = state_q;

endmodule

`default_nettype wire

@@ hdl/sgr_out_buf.sv @@
// sgr_out_buf: output register with a skid stage so a stalled result does not
// block the input side. Depends on sgr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sgr_out_buf
  import sgr_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     rsp_valid_i,
  input  sgr_out_t rsp_i,
  output logic     space_o,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output sgr_out_t out_rsp_o
);

  logic     out_valid_q, out_valid_d, skid_valid_q, skid_valid_d;
  sgr_out_t out_q, out_d, skid_q, skid_d;
  logic     out_fire;

  always_comb begin
    out_fire     = out_valid_q && out_ready_i;
    out_valid_d  = out_valid_q;
    out_d        = out_q;
    skid_valid_d = skid_valid_q;
    skid_d       = skid_q;
    if (skid_valid_q) begin
      if (out_fire) begin
        out_d        = skid_q;
        skid_valid_d = 1'b0;
      end
    end else if (!out_valid_q || out_fire) begin
      out_valid_d = rsp_valid_i;
      out_d       = rsp_i;
    end else if (rsp_valid_i) begin
      // output stalled: park the new result
      skid_valid_d = 1'b1;
      skid_d       = rsp_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign space_o     = !skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

endmodule

`default_nettype wire

@@ hdl/sgr_checker.sv @@
// sgr_checker: port-level assertions for the swipe gesture recognizer,
// bound to the top level. Depends on sgr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sgr_checker
  import sgr_pkg::*;
(
  input logic     clk_i,
  input logic     rst_ni,
  input logic     in_valid_i,
  input logic     in_ready_o,
  input sgr_in_t  in_req_i,
  input logic     out_valid_o,
  input logic     out_ready_i,
  input sgr_out_t out_rsp_o
);

  // no result can be pending right after a reset edge
  a_reset_idle: assert property (@(posedge clk_i) !rst_ni |=> !out_valid_o)
    else $error("result valid after reset");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_rsp_o))
    else $error("stalled result changed");

  // a fresh result only follows a contact-up request
  a_out_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && in_ready_o && in_req_i.kind == KindUp))
    else $error("result without contact-up request");

  // input back-pressure only while a result is waiting
  a_ready_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o)
    else $error("input stalled with no pending result");

endmodule

bind swipe_gesture_recognizer sgr_checker u_sgr_checker (.*);

`default_nettype wire
